>>> design/edfq_pkg.sv
`timescale 1ns / 1ps

package edfq_pkg;

    localparam int ENTRIES  = 16;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);

    localparam int OP_W     = 3;
    localparam int ID_W     = 16;
    localparam int DL_W     = 48;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 2;
    localparam int QCNT_W   = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_FIND    = 3'd2,
        OP_ENQUEUE = 3'd3,
        OP_DEQUEUE = 3'd4,
        OP_PEEK    = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_UPDATE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [DL_W-1:0]    deadline;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

endpackage

>>> design/edf_ready_queue.sv
`timescale 1ns / 1ps
// Takes one item at a time: s_ready is high only while idle. The single read port of the entry
// memory is swept once for the id lookup and once for the earliest-deadline search.
// A finished result waits in the output register.
// Reset (aresetn low, synchronous) clears the valid and queued bits, the enqueue counter
// and the control state; the entry memory holds no reset and is read only where valid.
module edf_ready_queue (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [edfq_pkg::OP_W-1:0]      s_operation,
    input  logic [edfq_pkg::ID_W-1:0]      s_task_id,
    input  logic [edfq_pkg::DL_W-1:0]      s_deadline,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [edfq_pkg::STATUS_W-1:0]  m_status,
    output logic                           m_found,
    output logic                           m_task_queued,
    output logic                           m_earliest_valid,
    output logic [edfq_pkg::ID_W-1:0]      m_earliest_id,
    output logic [edfq_pkg::DL_W-1:0]      m_earliest_deadline,
    output logic [edfq_pkg::QCNT_W-1:0]    m_queued_count
);
    import edfq_pkg::*;

    // entry memory: id, deadline, order stamp
    entry_t mem [ENTRIES];

    state_t state_reg, state_next;

    op_t                op_reg, op_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [DL_W-1:0]    dl_reg, dl_next;

    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] queued_reg, queued_next;
    logic [STAMP_W-1:0] counter_reg, counter_next;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               rvalid_reg;
    logic [IDX_W-1:0]   ridx_reg;
    entry_t             rdata_reg;

    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    status_t            status_reg, status_next;

    logic               best_v_reg, best_v_next;
    logic [ID_W-1:0]    best_id_reg, best_id_next;
    logic [DL_W-1:0]    best_dl_reg, best_dl_next;
    logic [STAMP_W-1:0] best_age_reg, best_age_next;
    logic [CNT_W-1:0]   qcnt_reg, qcnt_next;

    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic               m_found_reg, m_found_next;
    logic               m_tq_reg, m_tq_next;
    logic               m_ev_reg, m_ev_next;
    logic [ID_W-1:0]    m_eid_reg, m_eid_next;
    logic [DL_W-1:0]    m_edl_reg, m_edl_next;
    logic [QCNT_W-1:0]  m_qcnt_reg, m_qcnt_next;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    logic               last_rd;
    logic               free_v;
    logic [IDX_W-1:0]   free_idx;
    logic [STAMP_W-1:0] age_cur;

    assign rd_en   = ((state_reg == S_LOOKUP) || (state_reg == S_SCAN))
                     && (cnt_reg < CNT_W'(ENTRIES));
    assign rd_addr = cnt_reg[IDX_W-1:0];
    assign last_rd = rvalid_reg && (ridx_reg == IDX_W'(ENTRIES - 1));
    assign age_cur = counter_reg - rdata_reg.stamp;

    // lowest free slot
    always_comb begin
        free_v   = 1'b0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_v   = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
        ridx_reg <= rd_addr;
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        id_next       = id_reg;
        dl_next       = dl_reg;
        valid_next    = valid_reg;
        queued_next   = queued_reg;
        counter_next  = counter_reg;
        cnt_next      = cnt_reg;
        hit_next      = hit_reg;
        slot_next     = slot_reg;
        status_next   = status_reg;
        best_v_next   = best_v_reg;
        best_id_next  = best_id_reg;
        best_dl_next  = best_dl_reg;
        best_age_next = best_age_reg;
        qcnt_next     = qcnt_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_found_next  = m_found_reg;
        m_tq_next     = m_tq_reg;
        m_ev_next     = m_ev_reg;
        m_eid_next    = m_eid_reg;
        m_edl_next    = m_edl_reg;
        m_qcnt_next   = m_qcnt_reg;
        wr_en         = 1'b0;
        wr_addr       = slot_reg;
        wr_data       = '0;
        s_ready       = (state_reg == S_IDLE);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (rd_en) begin
            cnt_next = cnt_reg + 1'b1;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next     = op_t'(s_operation);
                    id_next     = s_task_id;
                    dl_next     = s_deadline;
                    hit_next    = 1'b0;
                    slot_next   = '0;
                    cnt_next    = '0;
                    state_next  = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (rvalid_reg && !hit_reg && valid_reg[ridx_reg]
                    && (rdata_reg.id == id_reg)) begin
                    hit_next  = 1'b1;
                    slot_next = ridx_reg;
                end
                if (last_rd) begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                status_next = ST_OK;
                case (op_reg)
                    OP_ADD: begin
                        if (!hit_reg) begin
                            if (!free_v) begin
                                status_next = ST_FULL;
                            end else begin
                                valid_next[free_idx]  = 1'b1;
                                queued_next[free_idx] = 1'b0;
                                wr_en      = 1'b1;
                                wr_addr    = free_idx;
                                wr_data.id = id_reg;
                                hit_next   = 1'b1;
                                slot_next  = free_idx;
                            end
                        end
                    end
                    OP_REMOVE: begin
                        if (!hit_reg) begin
                            status_next = ST_NOT_FOUND;
                        end else begin
                            valid_next[slot_reg]  = 1'b0;
                            queued_next[slot_reg] = 1'b0;
                            hit_next = 1'b0;
                        end
                    end
                    OP_FIND: begin
                        if (!hit_reg) begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    OP_ENQUEUE: begin
                        if (!hit_reg) begin
                            status_next = ST_NOT_FOUND;
                        end else begin
                            // id matched, so the whole entry can be rewritten
                            queued_next[slot_reg] = 1'b1;
                            wr_en            = 1'b1;
                            wr_data.id       = id_reg;
                            wr_data.deadline = dl_reg;
                            wr_data.stamp    = counter_reg;
                            counter_next     = counter_reg + 1'b1;
                        end
                    end
                    OP_DEQUEUE: begin
                        if (!hit_reg) begin
                            status_next = ST_NOT_FOUND;
                        end else begin
                            queued_next[slot_reg] = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
                best_v_next   = 1'b0;
                best_id_next  = '0;
                best_dl_next  = '0;
                best_age_next = '0;
                qcnt_next     = '0;
                cnt_next      = '0;
                state_next    = S_SCAN;
            end
            S_SCAN: begin
                if (rvalid_reg && valid_reg[ridx_reg] && queued_reg[ridx_reg]) begin
                    qcnt_next = qcnt_reg + 1'b1;
                    // older stamp wins a deadline tie
                    if (!best_v_reg || (rdata_reg.deadline < best_dl_reg)
                        || ((rdata_reg.deadline == best_dl_reg)
                            && (age_cur > best_age_reg))) begin
                        best_v_next   = 1'b1;
                        best_id_next  = rdata_reg.id;
                        best_dl_next  = rdata_reg.deadline;
                        best_age_next = age_cur;
                    end
                end
                if (last_rd) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_found_next  = hit_reg;
                    m_tq_next     = hit_reg && queued_reg[slot_reg];
                    m_ev_next     = best_v_reg;
                    m_eid_next    = best_id_reg;
                    m_edl_next    = best_dl_reg;
                    m_qcnt_next   = QCNT_W'(qcnt_reg);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            queued_reg  <= '0;
            counter_reg <= '0;
            cnt_reg     <= '0;
            rvalid_reg  <= 1'b0;
            hit_reg     <= 1'b0;
            best_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            queued_reg  <= queued_next;
            counter_reg <= counter_next;
            cnt_reg     <= cnt_next;
            rvalid_reg  <= rd_en;
            hit_reg     <= hit_next;
            best_v_reg  <= best_v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        dl_reg       <= dl_next;
        slot_reg     <= slot_next;
        status_reg   <= status_next;
        best_id_reg  <= best_id_next;
        best_dl_reg  <= best_dl_next;
        best_age_reg <= best_age_next;
        qcnt_reg     <= qcnt_next;
        m_status_reg <= m_status_next;
        m_found_reg  <= m_found_next;
        m_tq_reg     <= m_tq_next;
        m_ev_reg     <= m_ev_next;
        m_eid_reg    <= m_eid_next;
        m_edl_reg    <= m_edl_next;
        m_qcnt_reg   <= m_qcnt_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = m_status_reg;
    assign m_found             = m_found_reg;
    assign m_task_queued       = m_tq_reg;
    assign m_earliest_valid    = m_ev_reg;
    assign m_earliest_id       = m_eid_reg;
    assign m_earliest_deadline = m_edl_reg;
    assign m_queued_count      = m_qcnt_reg;

endmodule
